// ===== rtl/core/ufs_pkg.sv =====
// Shared types, constants and the flow index function for the UDP flow signature sequencer.
// Used by ufs_match and the top level in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package ufs_pkg;

  // Number of flow entries; a power of two, 1 .. 65536.
  localparam int unsigned FLOWS      = 1024;
  localparam int unsigned FLOW_IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  // Field widths of the descriptor and the result.
  localparam int unsigned FLOW_ID_W = 10;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned STAGE_W   = 5;
  localparam int unsigned VERDICT_W = 2;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // Signature constants.
  localparam logic [WORD_W-1:0] W_010B = 16'h010b;
  localparam logic [WORD_W-1:0] W_01C9 = 16'h01c9;
  localparam logic [WORD_W-1:0] W_0165 = 16'h0165;
  localparam logic [WORD_W-1:0] W_0101 = 16'h0101;
  localparam logic [WORD_W-1:0] W_0102 = 16'h0102;
  localparam logic [WORD_W-1:0] W_01CA = 16'h01ca;
  localparam logic [WORD_W-1:0] W_010C = 16'h010c;
  localparam logic [WORD_W-1:0] W_0115 = 16'h0115;
  localparam logic [WORD_W-1:0] W_0166 = 16'h0166;

  localparam logic [LEN_W-1:0] LEN_16  = 16'd16;
  localparam logic [LEN_W-1:0] LEN_32  = 16'd32;
  localparam logic [LEN_W-1:0] LEN_64  = 16'd64;
  localparam logic [LEN_W-1:0] LEN_88  = 16'd88;
  localparam logic [LEN_W-1:0] LEN_100 = 16'd100;
  localparam logic [LEN_W-1:0] LEN_104 = 16'd104;
  localparam logic [LEN_W-1:0] LEN_136 = 16'd136;

  // Verdict codes.
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ADVANCE     = 2'd0,
    VERDICT_DETECT      = 2'd1,
    VERDICT_EXCLUDE_NOW = 2'd2,
    VERDICT_EXCLUDED    = 2'd3
  } verdict_e;

  // One flow table entry.
  typedef struct packed {
    logic               excl;
    logic [STAGE_W-1:0] stage;
  } flow_entry_t;

  localparam int unsigned ENTRY_W = $bits(flow_entry_t);

  // Outcome of one signature step.
  typedef struct packed {
    logic               hit;
    logic               detect;
    logic [STAGE_W-1:0] next_stage;
  } match_res_t;

  // Table entry of a flow number: the low index bits, since FLOWS is a power of two.
  function automatic logic [FLOW_IDX_W-1:0] flow_index(input logic [FLOW_ID_W-1:0] fid);
    logic [FLOW_ID_W+FLOW_IDX_W-1:0] ext;
    ext = {{FLOW_IDX_W{1'b0}}, fid};
    return ext[FLOW_IDX_W-1:0] & FLOW_IDX_W'(FLOWS - 1);
  endfunction

endpackage

// ===== rtl/core/ufs_ram.sv =====
// Generic single-write, single-read RAM with a registered, read-first output.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module ufs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read of the entry being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ufs_match.sv =====
// Signature step logic: next stage and detection for one stage, length and first word.
// Depends on ufs_pkg.
`timescale 1ns / 1ps

module ufs_match (
  input  logic [ufs_pkg::STAGE_W-1:0] stage_i,
  input  logic [ufs_pkg::LEN_W-1:0]   len_i,
  input  logic [ufs_pkg::WORD_W-1:0]  word_i,
  output ufs_pkg::match_res_t         res_o
);

  logic big;
  logic c136;
  logic p64_010b, p88_0101, p104_0102, p32_01ca, p16_010c, p88_0115, p136_0166;
  logic big_0115;

  // Pattern terms, most of them shared by several stages.
  always_comb begin
    big       = len_i > ufs_pkg::LEN_100;
    c136      = (len_i == ufs_pkg::LEN_136) &&
                ((word_i == ufs_pkg::W_01C9) || (word_i == ufs_pkg::W_0165));
    p64_010b  = (len_i == ufs_pkg::LEN_64)  && (word_i == ufs_pkg::W_010B);
    p88_0101  = (len_i == ufs_pkg::LEN_88)  && (word_i == ufs_pkg::W_0101);
    p104_0102 = (len_i == ufs_pkg::LEN_104) && (word_i == ufs_pkg::W_0102);
    p32_01ca  = (len_i == ufs_pkg::LEN_32)  && (word_i == ufs_pkg::W_01CA);
    p16_010c  = (len_i == ufs_pkg::LEN_16)  && (word_i == ufs_pkg::W_010C);
    p88_0115  = (len_i == ufs_pkg::LEN_88)  && (word_i == ufs_pkg::W_0115);
    p136_0166 = (len_i == ufs_pkg::LEN_136) && (word_i == ufs_pkg::W_0166);
    big_0115  = big && (word_i == ufs_pkg::W_0115);
  end

  // Transition table. Detecting stages keep their stage.
  always_comb begin
    res_o.hit        = 1'b0;
    res_o.detect     = 1'b0;
    res_o.next_stage = stage_i;
    unique case (stage_i)
      5'd0: begin
        res_o.hit = 1'b1;
        if (p64_010b)       res_o.next_stage = 5'd1;
        else if (c136)      res_o.next_stage = 5'd4;
        else if (p88_0101)  res_o.next_stage = 5'd7;
        else if (p104_0102) res_o.next_stage = 5'd10;
        else if (p32_01ca)  res_o.next_stage = 5'd13;
        else if (p16_010c)  res_o.next_stage = 5'd16;
        else                res_o.hit = 1'b0;
      end
      5'd1: begin
        res_o.hit = big_0115;
        res_o.next_stage = 5'd2;
      end
      5'd2: begin
        res_o.hit = p16_010c || p64_010b || p88_0115;
        res_o.next_stage = 5'd3;
      end
      5'd3: begin
        res_o.hit    = p16_010c || p64_010b || big_0115;
        res_o.detect = 1'b1;
      end
      5'd4, 5'd5: begin
        res_o.hit = c136;
        res_o.next_stage = stage_i + 5'd1;
      end
      5'd6: begin
        res_o.hit    = c136 || p32_01ca;
        res_o.detect = 1'b1;
      end
      5'd7, 5'd8: begin
        res_o.hit = p88_0101;
        res_o.next_stage = stage_i + 5'd1;
      end
      5'd9: begin
        res_o.hit    = p88_0101;
        res_o.detect = 1'b1;
      end
      5'd10, 5'd11: begin
        res_o.hit = p104_0102;
        res_o.next_stage = stage_i + 5'd1;
      end
      5'd12: begin
        res_o.hit    = p104_0102 || p32_01ca;
        res_o.detect = 1'b1;
      end
      5'd13: begin
        res_o.hit = p32_01ca;
        res_o.next_stage = 5'd14;
      end
      5'd14: begin
        res_o.hit = p32_01ca || p136_0166;
        res_o.next_stage = 5'd15;
      end
      5'd15: begin
        res_o.hit    = p136_0166 || p32_01ca;
        res_o.detect = 1'b1;
      end
      5'd16, 5'd17: begin
        res_o.hit = p16_010c;
        res_o.next_stage = stage_i + 5'd1;
      end
      5'd18: begin
        res_o.hit    = p16_010c;
        res_o.detect = 1'b1;
      end
      default: begin
        res_o.hit = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/udp_flow_signature_sequencer.sv =====
// Top level of the UDP flow signature sequencer: flow table RAM, read-modify-write
// pipeline with forwarding, clearing pass and output register.
// Depends on ufs_pkg, ufs_ram and ufs_match.
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit first)                           tuser
// s_axis    in         flow_id[9:0] payload_len[25:10] first_word[41:26] flow_start
// m_axis    out        flow_tag[9:0] verdict[11:10] stage_now[16:12]  -
//
// One descriptor per cycle while no clearing pass runs and m_axis does not stall; each
// result passes the lookup stage registers and then the output register.
// The flow table is one RAM read at accept time and written back when the lookup stage
// passes its result on, which waits while m_axis stalls; the last write is forwarded to
// the next descriptor, so no hazard stalls occur.
// After reset a clearing pass zeroes all FLOWS entries of the table, with s_axis not ready.
// A stalled m_axis holds one result; one more descriptor is taken before s_axis stalls.

module udp_flow_signature_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ufs_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // flow_id, payload_len, first_word
  input  logic                           s_axis_tuser_i,  // flow_start
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ufs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o   // flow_tag, verdict, stage_now
);

  localparam int unsigned IW = ufs_pkg::FLOW_IDX_W;

  // Input field split.
  logic [ufs_pkg::FLOW_ID_W-1:0] in_fid;
  logic [ufs_pkg::LEN_W-1:0]     in_len;
  logic [ufs_pkg::WORD_W-1:0]    in_word;

  assign in_fid  = s_axis_tdata_i[9:0];
  assign in_len  = s_axis_tdata_i[25:10];
  assign in_word = s_axis_tdata_i[41:26];

  // Clearing pass state.
  logic          clr_active_q, clr_active_d;
  logic [IW-1:0] clr_cnt_q, clr_cnt_d;

  // Lookup stage registers.
  logic                          s1_valid_q, s1_valid_d;
  logic [ufs_pkg::FLOW_ID_W-1:0] s1_fid_q;
  logic                          s1_start_q;
  logic [ufs_pkg::LEN_W-1:0]     s1_len_q;
  logic [ufs_pkg::WORD_W-1:0]    s1_word_q;

  // Last write-back, forwarded to the following lookup.
  logic                 fwd_valid_q, fwd_valid_d;
  logic [IW-1:0]        fwd_addr_q;
  ufs_pkg::flow_entry_t fwd_entry_q;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic [ufs_pkg::FLOW_ID_W-1:0]   out_fid_q;
  ufs_pkg::verdict_e               out_verdict_q;
  logic [ufs_pkg::STAGE_W-1:0]     out_stage_q;

  logic                 s_fire, s1_fire, out_free;
  logic [IW-1:0]        s1_idx;
  ufs_pkg::flow_entry_t ram_rdata, entry_rd, entry_cur, entry_new;
  ufs_pkg::match_res_t  mres;
  ufs_pkg::verdict_e    verdict;
  logic [ufs_pkg::STAGE_W-1:0] stage_out;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  ufs_pkg::flow_entry_t ram_wdata;

  // Handshakes.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_fire         = s1_valid_q && out_free;
  assign s_axis_tready_o = !clr_active_q && (!s1_valid_q || s1_fire);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Flow table.
  ufs_ram #(
    .WIDTH (ufs_pkg::ENTRY_W),
    .DEPTH (ufs_pkg::FLOWS)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s_fire),
    .raddr_i (ufs_pkg::flow_index(in_fid)),
    .rdata_o (ram_rdata)
  );

  // Entry seen by the lookup stage: forwarded write first, then flow start clear.
  always_comb begin
    s1_idx    = ufs_pkg::flow_index(s1_fid_q);
    entry_rd  = (fwd_valid_q && (fwd_addr_q == s1_idx)) ? fwd_entry_q : ram_rdata;
    entry_cur = s1_start_q ? '0 : entry_rd;
  end

  ufs_match u_match (
    .stage_i (entry_cur.stage),
    .len_i   (s1_len_q),
    .word_i  (s1_word_q),
    .res_o   (mres)
  );

  // Verdict and updated entry.
  always_comb begin
    entry_new = entry_cur;
    stage_out = entry_cur.stage;
    if (entry_cur.excl) begin
      verdict = ufs_pkg::VERDICT_EXCLUDED;
    end else if (!mres.hit) begin
      verdict        = ufs_pkg::VERDICT_EXCLUDE_NOW;
      entry_new.excl = 1'b1;
    end else if (mres.detect) begin
      verdict = ufs_pkg::VERDICT_DETECT;
    end else begin
      verdict         = ufs_pkg::VERDICT_ADVANCE;
      entry_new.stage = mres.next_stage;
      stage_out       = mres.next_stage;
    end
  end

  // Write port: the clearing pass, otherwise the write-back of the lookup stage.
  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_fire;
      ram_waddr = s1_idx;
      ram_wdata = entry_new;
    end
  end

  // Next values of control registers.
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + IW'(1);
      if (clr_cnt_q == IW'(ufs_pkg::FLOWS - 1)) begin
        clr_active_d = 1'b0;
      end
    end
    s1_valid_d  = s_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    fwd_valid_d = fwd_valid_q || s1_fire;
    out_valid_d = s1_fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      s1_valid_q   <= s1_valid_d;
      fwd_valid_q  <= fwd_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_fid_q   <= in_fid;
      s1_start_q <= s_axis_tuser_i;
      s1_len_q   <= in_len;
      s1_word_q  <= in_word;
    end
    if (s1_fire) begin
      fwd_addr_q    <= s1_idx;
      fwd_entry_q   <= entry_new;
      out_fid_q     <= s1_fid_q;
      out_verdict_q <= verdict;
      out_stage_q   <= stage_out;
    end
  end

  // Result transfer.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_stage_q, out_verdict_q, out_fid_q};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for udp_flow_signature_sequencer: directed signature chains,
// then interleaved random chains with corruption and noise, checked against an in-bench model.
// Depends on ufs_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import ufs_pkg::*;

  // One packet descriptor as offered on the input stream.
  typedef struct {
    logic [FLOW_ID_W-1:0] fid;
    logic                 start;
    logic [LEN_W-1:0]     len;
    logic [WORD_W-1:0]    word;
  } pkt_desc_t;

  // One classification result as expected on the output stream.
  typedef struct {
    logic [FLOW_ID_W-1:0] tag;
    verdict_e             verdict;
    logic [STAGE_W-1:0]   stage;
  } flow_result_t;

  // Signature chains, named after the length of their entry packet.
  typedef enum int {
    CHAIN_LEN64  = 0,
    CHAIN_LEN136 = 1,
    CHAIN_LEN88  = 2,
    CHAIN_LEN104 = 3,
    CHAIN_LEN32  = 4,
    CHAIN_LEN16  = 5
  } chain_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;  // flow_id, payload_len, first_word
  logic                  s_axis_tuser_i = 1'b0; // flow_start
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;       // flow_tag, verdict, stage_now

  // Shadow of the flow table.
  logic [STAGE_W-1:0]    stage_mem [FLOWS];
  logic                  excl_mem [FLOWS];

  pkt_desc_t             pkt_q [$];
  flow_result_t          verdict_q [$];

  int                    pkt_cnt = 0;
  int                    accepted_cnt = 0;
  int                    result_cnt = 0;
  int                    err_cnt = 0;
  logic                  s_fire = 1'b0;
  logic                  m_fire = 1'b0;
  int                    send_gap = 0;
  int                    recv_gap = 0;
  logic                  send_busy = 1'b1;
  logic                  recv_busy = 1'b1;
  logic                  rx_hold = 1'b0;

  udp_flow_signature_sequencer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    foreach (stage_mem[i]) begin
      stage_mem[i] = '0;
      excl_mem[i]  = 1'b0;
    end
  end

  // Classifies one descriptor and updates the shadow table of its flow.
  function automatic void classify_packet(input pkt_desc_t pkt, output flow_result_t res);
    logic [FLOW_IDX_W-1:0] idx;
    logic [STAGE_W-1:0]    st;
    logic [STAGE_W-1:0]    nxt;
    logic                  hit;
    logic                  det;
    logic                  big, c136, m16, m32, m64, m88a, m88b, m104, m136b;
    idx   = FLOW_IDX_W'(pkt.fid % FLOWS);
    big   = pkt.len > LEN_100;
    c136  = pkt.len == LEN_136 && (pkt.word == W_01C9 || pkt.word == W_0165);
    m16   = pkt.len == LEN_16 && pkt.word == W_010C;
    m32   = pkt.len == LEN_32 && pkt.word == W_01CA;
    m64   = pkt.len == LEN_64 && pkt.word == W_010B;
    m88a  = pkt.len == LEN_88 && pkt.word == W_0101;
    m88b  = pkt.len == LEN_88 && pkt.word == W_0115;
    m104  = pkt.len == LEN_104 && pkt.word == W_0102;
    m136b = pkt.len == LEN_136 && pkt.word == W_0166;

    // A flow start clears the entry before the packet is looked at.
    if (pkt.start) begin
      stage_mem[idx] = '0;
      excl_mem[idx]  = 1'b0;
    end
    st      = stage_mem[idx];
    res.tag = pkt.fid;

    if (excl_mem[idx]) begin
      res.verdict = VERDICT_EXCLUDED;
    end else begin
      hit = 1'b1;
      det = 1'b0;
      nxt = st;
      case (st)
        0: begin
          if (m64) nxt = 1;
          else if (c136) nxt = 4;
          else if (m88a) nxt = 7;
          else if (m104) nxt = 10;
          else if (m32) nxt = 13;
          else if (m16) nxt = 16;
          else hit = 1'b0;
        end
        1: begin
          if (big && pkt.word == W_0115) nxt = 2;
          else hit = 1'b0;
        end
        2: begin
          if (m16 || m64 || m88b) nxt = 3;
          else hit = 1'b0;
        end
        3: begin
          det = m16 || m64 || (big && pkt.word == W_0115);
          hit = det;
        end
        4, 5: begin
          if (c136) nxt = st + 1'b1;
          else hit = 1'b0;
        end
        6: begin
          det = c136 || m32;
          hit = det;
        end
        7, 8: begin
          if (m88a) nxt = st + 1'b1;
          else hit = 1'b0;
        end
        9: begin
          det = m88a;
          hit = det;
        end
        10, 11: begin
          if (m104) nxt = st + 1'b1;
          else hit = 1'b0;
        end
        12: begin
          det = m104 || m32;
          hit = det;
        end
        13: begin
          if (m32) nxt = 14;
          else hit = 1'b0;
        end
        14: begin
          if (m32 || m136b) nxt = 15;
          else hit = 1'b0;
        end
        15: begin
          det = m136b || m32;
          hit = det;
        end
        16, 17: begin
          if (m16) nxt = st + 1'b1;
          else hit = 1'b0;
        end
        18: begin
          det = m16;
          hit = det;
        end
        default: hit = 1'b0;
      endcase

      // A miss excludes the flow and keeps its stage; a detection changes nothing.
      if (!hit) begin
        excl_mem[idx] = 1'b1;
        res.verdict   = VERDICT_EXCLUDE_NOW;
      end else if (det) begin
        res.verdict = VERDICT_DETECT;
      end else begin
        st             = nxt;
        stage_mem[idx] = nxt;
        res.verdict    = VERDICT_ADVANCE;
      end
    end
    res.stage = st;
  endfunction

  task automatic push_pkt(input int fid, input bit start, input int len, input int word);
    pkt_desc_t pkt;
    pkt.fid   = FLOW_ID_W'(fid);
    pkt.start = start;
    pkt.len   = LEN_W'(len);
    pkt.word  = WORD_W'(word);
    pkt_q.push_back(pkt);
    pkt_cnt++;
  endtask

  // Picks a matching (length, word) pair for the given step of a chain.
  function automatic void chain_packet(input chain_kind_e kind, input int step,
                                       output logic [LEN_W-1:0] len,
                                       output logic [WORD_W-1:0] word);
    int pick;
    pick = $urandom_range(0, 2);
    case (kind)
      CHAIN_LEN64: begin
        if (step == 0) begin
          len = LEN_64; word = W_010B;
        end else if (step == 1 || pick == 2) begin
          len = LEN_W'($urandom_range(101, 65535)); word = W_0115;
          if (step == 2) len = LEN_88;
        end else if (pick == 0) begin
          len = LEN_16; word = W_010C;
        end else begin
          len = LEN_64; word = W_010B;
        end
      end
      CHAIN_LEN136: begin
        len  = LEN_136;
        word = pick[0] ? W_01C9 : W_0165;
        if (step >= 3 && pick == 2) begin
          len = LEN_32; word = W_01CA;
        end
      end
      CHAIN_LEN88: begin
        len = LEN_88; word = W_0101;
      end
      CHAIN_LEN104: begin
        len = LEN_104; word = W_0102;
        if (step >= 3 && pick == 2) begin
          len = LEN_32; word = W_01CA;
        end
      end
      CHAIN_LEN32: begin
        len = LEN_32; word = W_01CA;
        if (step >= 2 && pick != 0) begin
          len = LEN_136; word = W_0166;
        end
      end
      default: begin
        len = LEN_16; word = W_010C;
      end
    endcase
  endfunction

  // Interleaves up to four signature chains on random flows, with the odd corrupted
  // field, missing flow start and pure noise packet.
  task automatic add_random(input int count);
    chain_kind_e          kind [4];
    int                   step [4];
    int                   left [4];
    int                   flow [4];
    int                   slot;
    logic [LEN_W-1:0]     len;
    logic [WORD_W-1:0]    word;
    foreach (left[i]) left[i] = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        push_pkt($urandom_range(0, 1023), $urandom_range(0, 1),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        slot = $urandom_range(0, 3);
        if (left[slot] == 0) begin
          kind[slot] = chain_kind_e'($urandom_range(0, 5));
          flow[slot] = $urandom_range(0, 1023);
          step[slot] = 0;
          left[slot] = 4 + $urandom_range(0, 2);
        end
        chain_packet(kind[slot], step[slot], len, word);
        if ($urandom_range(0, 19) == 0) begin
          if ($urandom_range(0, 1)) len ^= LEN_W'(1) << $urandom_range(0, 15);
          else word ^= WORD_W'(1) << $urandom_range(0, 15);
        end
        push_pkt(flow[slot], step[slot] == 0 && $urandom_range(0, 9) != 0, len, word);
        step[slot]++;
        left[slot]--;
      end
    end
  endtask

  task automatic report_fail(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk_i) begin : monitor
    flow_result_t       want;
    flow_result_t       res;
    pkt_desc_t          pkt;
    logic [FLOW_ID_W-1:0] got_tag;
    logic [VERDICT_W-1:0] got_verdict;
    logic [STAGE_W-1:0]   got_stage;
    s_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    m_fire <= rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      pkt.fid   = s_axis_tdata_i[9:0];
      pkt.len   = s_axis_tdata_i[25:10];
      pkt.word  = s_axis_tdata_i[41:26];
      pkt.start = s_axis_tuser_i;
      classify_packet(pkt, res);
      verdict_q.push_back(res);
      accepted_cnt++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_tag     = m_axis_tdata_o[9:0];
      got_verdict = m_axis_tdata_o[11:10];
      got_stage   = m_axis_tdata_o[16:12];
      result_cnt++;
      if (verdict_q.size() == 0) begin
        report_fail($sformatf("result with nothing expected: tag %0d verdict %0d stage %0d",
                              got_tag, got_verdict, got_stage));
      end else begin
        want = verdict_q.pop_front();
        if (got_tag !== want.tag || got_verdict !== want.verdict ||
            got_stage !== want.stage) begin
          report_fail($sformatf("expected tag %0d verdict %0d stage %0d, got %0d %0d %0d",
                                want.tag, want.verdict, want.stage,
                                got_tag, got_verdict, got_stage));
        end
      end
    end
  end

  // Driver: offers queued descriptors, with a random gap before each one.
  always @(negedge clk_i) begin : driver
    pkt_desc_t pkt;
    if (rst_ni && (!s_axis_tvalid_i || s_fire)) begin
      if (send_gap > 0) begin
        send_gap        <= send_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pkt_q.size() > 0) begin
        pkt             = pkt_q.pop_front();
        s_axis_tdata_i  <= {6'b0, pkt.word, pkt.len, pkt.fid};
        s_axis_tuser_i  <= pkt.start;
        s_axis_tvalid_i <= 1'b1;
        send_gap        <= send_busy ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 63) == 0) send_busy <= !send_busy;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: stalls for a random number of cycles after each transfer, and while rx_hold is set.
  always @(negedge clk_i) begin : receiver
    int gap_now;
    if (rst_ni) begin
      gap_now = recv_gap;
      if (m_fire) begin
        gap_now = recv_busy ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 63) == 0) recv_busy <= !recv_busy;
      end
      if (rx_hold) begin
        m_axis_tready_i <= 1'b0;
        recv_gap        <= gap_now;
      end else if (gap_now > 0) begin
        m_axis_tready_i <= 1'b0;
        recv_gap        <= gap_now - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
        recv_gap        <= 0;
      end
    end
  end

  // Long output stall while the input side keeps offering, to fill the pipeline.
  initial begin : backpressure
    wait (accepted_cnt >= 150);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Every chain but the length-16 one walked through to detection, on the extreme flow numbers too.
    push_pkt(0, 1'b1, 64, 16'h010b);
    push_pkt(0, 1'b0, 65535, 16'h0115);
    push_pkt(0, 1'b0, 88, 16'h0115);
    push_pkt(0, 1'b0, 16, 16'h010c);
    push_pkt(1023, 1'b1, 136, 16'h0165);
    push_pkt(1023, 1'b0, 136, 16'h01c9);
    push_pkt(1023, 1'b0, 136, 16'h01c9);
    push_pkt(1023, 1'b0, 32, 16'h01ca);
    push_pkt(2, 1'b0, 88, 16'h0101);
    push_pkt(2, 1'b0, 88, 16'h0101);
    push_pkt(2, 1'b0, 88, 16'h0101);
    push_pkt(2, 1'b0, 88, 16'h0101);
    push_pkt(3, 1'b0, 104, 16'h0102);
    push_pkt(3, 1'b0, 104, 16'h0102);
    push_pkt(3, 1'b0, 104, 16'h0102);
    push_pkt(3, 1'b0, 32, 16'h01ca);
    push_pkt(4, 1'b0, 32, 16'h01ca);
    push_pkt(4, 1'b0, 32, 16'h01ca);
    push_pkt(4, 1'b0, 136, 16'h0166);
    push_pkt(4, 1'b0, 136, 16'h0166);
    // Detection repeats; a short length misses the big-length match and excludes.
    push_pkt(0, 1'b0, 101, 16'h0115);
    push_pkt(0, 1'b0, 100, 16'h0115);
    // Exclusion of a fresh flow, a skipped packet, then a flow start clearing it.
    push_pkt(6, 1'b0, 0, 16'h0000);
    push_pkt(6, 1'b0, 65535, 16'hffff);
    push_pkt(6, 1'b1, 16, 16'h010c);
    wait (result_cnt >= pkt_cnt);

    add_random(360);
    wait (result_cnt >= pkt_cnt);
    add_random(370);
    wait (result_cnt >= pkt_cnt);
    repeat (16) @(posedge clk_i);

    if (verdict_q.size() > 0) report_fail("expected results never arrived");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
